// ===== src/lis_pkg.sv =====
// lis_pkg: shared types, constants and lookup functions of the LED indicator sequencer
// no dependencies
package lis_pkg;

  typedef enum logic [2:0] {
    REQ_SET_IND = 3'd0,
    REQ_CLEAR   = 3'd1,
    REQ_CHASER  = 3'd2,
    REQ_SET_BIT = 3'd3,
    REQ_RESEND  = 3'd4,
    REQ_RAW     = 3'd5
  } req_e;

  typedef enum logic [1:0] {
    IND_NONE,
    IND_SHIFT,
    IND_DIRECT_A,
    IND_DIRECT_B
  } ind_kind_e;

  typedef struct packed {
    ind_kind_e  kind;
    logic [2:0] pos;
  } ind_t;

  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] led_number;
    logic       led_on;
    logic [7:0] raw_byte;
  } cmd_t;

  typedef struct packed {
    logic [7:0] shifted_byte;
    logic       shift_pulsed;
    logic       latch_pulsed;
    logic       direct_led_a;
    logic       direct_led_b;
    logic [6:0] hold_ms;
    logic       last;
  } res_t;

  typedef struct packed {
    logic [7:0] image;
    logic       direct_a;
    logic       direct_b;
    logic [6:0] hold;
  } frame_t;

  localparam int unsigned CHASER_FRAMES = 43;
  localparam int unsigned FRAME_W       = $clog2(CHASER_FRAMES);
  localparam logic [FRAME_W-1:0] CHASER_LAST = FRAME_W'(CHASER_FRAMES - 1);

  localparam logic [6:0] T_WIPE     = 7'd40;
  localparam logic [6:0] T_WIPE_OFF = T_WIPE >> 1;
  localparam logic [6:0] T_PHASE    = 7'd80;
  localparam logic [6:0] T_NONE     = 7'd0;

  // indicator number to shift bit or direct led
  function automatic ind_t ind_map(input logic [7:0] n);
    ind_t m;
    m.kind = IND_SHIFT;
    m.pos  = 3'd0;
    unique case (n)
      8'd1:    m.pos = 3'd0;
      8'd2:    m.pos = 3'd2;
      8'd3:    m.pos = 3'd4;
      8'd4:    m.pos = 3'd6;
      8'd5:    m.pos = 3'd1;
      8'd6:    m.kind = IND_DIRECT_A;
      8'd7:    m.pos = 3'd3;
      8'd8:    m.kind = IND_DIRECT_B;
      8'd9:    m.pos = 3'd7;
      8'd10:   m.pos = 3'd5;
      default: m.kind = IND_NONE;
    endcase
    return m;
  endfunction

  // startup animation, one entry per frame: wipe on, wipe off, dot forward,
  // dot backward, odd phase, even phase, all off
  function automatic frame_t chaser_frame(input logic [FRAME_W-1:0] idx);
    frame_t f;
    f = '{8'h00, 1'b0, 1'b0, T_NONE};
    unique case (idx)
      6'd0:    f = '{8'h01, 1'b0, 1'b0, T_WIPE};
      6'd1:    f = '{8'h05, 1'b0, 1'b0, T_WIPE};
      6'd2:    f = '{8'h15, 1'b0, 1'b0, T_WIPE};
      6'd3:    f = '{8'h55, 1'b0, 1'b0, T_WIPE};
      6'd4:    f = '{8'h57, 1'b0, 1'b0, T_WIPE};
      6'd5:    f = '{8'h57, 1'b1, 1'b0, T_WIPE};
      6'd6:    f = '{8'h5F, 1'b1, 1'b0, T_WIPE};
      6'd7:    f = '{8'h5F, 1'b1, 1'b1, T_WIPE};
      6'd8:    f = '{8'hDF, 1'b1, 1'b1, T_WIPE};
      6'd9:    f = '{8'hFF, 1'b1, 1'b1, T_WIPE};
      6'd10:   f = '{8'hFE, 1'b1, 1'b1, T_WIPE_OFF};
      6'd11:   f = '{8'hFA, 1'b1, 1'b1, T_WIPE_OFF};
      6'd12:   f = '{8'hEA, 1'b1, 1'b1, T_WIPE_OFF};
      6'd13:   f = '{8'hAA, 1'b1, 1'b1, T_WIPE_OFF};
      6'd14:   f = '{8'hA8, 1'b1, 1'b1, T_WIPE_OFF};
      6'd15:   f = '{8'hA8, 1'b0, 1'b1, T_WIPE_OFF};
      6'd16:   f = '{8'hA0, 1'b0, 1'b1, T_WIPE_OFF};
      6'd17:   f = '{8'hA0, 1'b0, 1'b0, T_WIPE_OFF};
      6'd18:   f = '{8'h20, 1'b0, 1'b0, T_WIPE_OFF};
      6'd19:   f = '{8'h00, 1'b0, 1'b0, T_WIPE_OFF};
      6'd20:   f = '{8'h01, 1'b0, 1'b0, T_WIPE};
      6'd21:   f = '{8'h04, 1'b0, 1'b0, T_WIPE};
      6'd22:   f = '{8'h10, 1'b0, 1'b0, T_WIPE};
      6'd23:   f = '{8'h40, 1'b0, 1'b0, T_WIPE};
      6'd24:   f = '{8'h02, 1'b0, 1'b0, T_WIPE};
      6'd25:   f = '{8'h00, 1'b1, 1'b0, T_WIPE};
      6'd26:   f = '{8'h08, 1'b0, 1'b0, T_WIPE};
      6'd27:   f = '{8'h00, 1'b0, 1'b1, T_WIPE};
      6'd28:   f = '{8'h80, 1'b0, 1'b0, T_WIPE};
      6'd29:   f = '{8'h20, 1'b0, 1'b0, T_WIPE};
      6'd30:   f = '{8'h20, 1'b0, 1'b0, T_WIPE};
      6'd31:   f = '{8'h80, 1'b0, 1'b0, T_WIPE};
      6'd32:   f = '{8'h00, 1'b0, 1'b1, T_WIPE};
      6'd33:   f = '{8'h08, 1'b0, 1'b0, T_WIPE};
      6'd34:   f = '{8'h00, 1'b1, 1'b0, T_WIPE};
      6'd35:   f = '{8'h02, 1'b0, 1'b0, T_WIPE};
      6'd36:   f = '{8'h40, 1'b0, 1'b0, T_WIPE};
      6'd37:   f = '{8'h10, 1'b0, 1'b0, T_WIPE};
      6'd38:   f = '{8'h04, 1'b0, 1'b0, T_WIPE};
      6'd39:   f = '{8'h01, 1'b0, 1'b0, T_WIPE};
      6'd40:   f = '{8'h9B, 1'b0, 1'b0, T_PHASE};
      6'd41:   f = '{8'h64, 1'b1, 1'b1, T_PHASE};
      default: f = '{8'h00, 1'b0, 1'b0, T_NONE};
    endcase
    return f;
  endfunction

endpackage

// ===== src/lis_if.sv =====
// lis_if: valid/ready channel interfaces for commands and results
// no dependencies
interface lis_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] req_type;
  logic [7:0] led_number;
  logic       led_on;
  logic [7:0] raw_byte;

  modport source (output valid, req_type, led_number, led_on, raw_byte, input ready);
  modport sink   (input valid, req_type, led_number, led_on, raw_byte, output ready);
endinterface

interface lis_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] shifted_byte;
  logic       shift_pulsed;
  logic       latch_pulsed;
  logic       direct_led_a;
  logic       direct_led_b;
  logic [6:0] hold_ms;
  logic       last;

  modport source (output valid, shifted_byte, shift_pulsed, latch_pulsed, direct_led_a,
                  direct_led_b, hold_ms, last, input ready);
  modport sink   (input valid, shifted_byte, shift_pulsed, latch_pulsed, direct_led_a,
                  direct_led_b, hold_ms, last, output ready);
endinterface

// ===== src/lis_engine.sv =====
// lis_engine: command register, chaser frame counter, led state and result logic
// depends on lis_pkg
module lis_engine (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic          cfg_wdata_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  lis_pkg::cmd_t in_cmd_i,
  output logic          res_valid_o,
  input  logic          res_ready_i,
  output lis_pkg::res_t res_o
);
  import lis_pkg::*;

  logic               fb_q;
  logic               cmd_vld_q, cmd_vld_d;
  cmd_t               cmd_q;
  logic [FRAME_W-1:0] frame_q, frame_d;
  logic [7:0]         image_q, image_d;
  logic               da_q, da_d;
  logic               db_q, db_d;

  logic   emit, done, advance, is_chaser;
  ind_t   ind;
  frame_t frm;
  res_t   res;

  always_comb begin
    ind       = ind_map(cmd_q.led_number);
    frm       = chaser_frame(frame_q);
    image_d   = image_q;
    da_d      = da_q;
    db_d      = db_q;
    emit      = 1'b0;
    done      = 1'b1;
    is_chaser = 1'b0;
    res       = '0;
    unique case (cmd_q.req_type)
      REQ_SET_IND: begin
        if (!fb_q) begin
          image_d = '0;
          da_d    = 1'b0;
          db_d    = 1'b0;
          emit    = 1'b1;
          res     = '{8'h00, 1'b1, 1'b1, 1'b0, 1'b0, T_NONE, 1'b1};
        end else begin
          unique case (ind.kind)
            IND_SHIFT: begin
              image_d[ind.pos] = cmd_q.led_on;
              emit = 1'b1;
              res  = '{image_d, 1'b1, 1'b1, da_q, db_q, T_NONE, 1'b1};
            end
            IND_DIRECT_A: begin
              da_d = cmd_q.led_on;
              emit = 1'b1;
              res  = '{8'h00, 1'b0, 1'b0, da_d, db_q, T_NONE, 1'b1};
            end
            IND_DIRECT_B: begin
              db_d = cmd_q.led_on;
              emit = 1'b1;
              res  = '{8'h00, 1'b0, 1'b0, da_q, db_d, T_NONE, 1'b1};
            end
            default: emit = 1'b0;
          endcase
        end
      end
      REQ_CLEAR: begin
        image_d = '0;
        da_d    = 1'b0;
        db_d    = 1'b0;
        emit    = 1'b1;
        res     = '{8'h00, 1'b1, 1'b1, 1'b0, 1'b0, T_NONE, 1'b1};
      end
      REQ_CHASER: begin
        // frames come from the table; the animation leaves everything off
        is_chaser = 1'b1;
        image_d   = '0;
        da_d      = 1'b0;
        db_d      = 1'b0;
        emit      = 1'b1;
        done      = (frame_q == CHASER_LAST);
        res       = '{frm.image, 1'b1, 1'b1, frm.direct_a, frm.direct_b, frm.hold, done};
      end
      REQ_SET_BIT: begin
        if (cmd_q.led_number[7:3] == 5'd0) begin
          image_d[cmd_q.led_number[2:0]] = cmd_q.led_on;
          emit = 1'b1;
          res  = '{image_d, 1'b1, 1'b1, da_q, db_q, T_NONE, 1'b1};
        end
      end
      REQ_RESEND: begin
        emit = 1'b1;
        res  = '{image_q, 1'b1, 1'b1, da_q, db_q, T_NONE, 1'b1};
      end
      REQ_RAW: begin
        emit = 1'b1;
        res  = '{cmd_q.raw_byte, 1'b1, 1'b0, da_q, db_q, T_NONE, 1'b1};
      end
      default: emit = 1'b0;
    endcase

    // items without a result retire without waiting on the output side
    advance    = cmd_vld_q && (!emit || res_ready_i);
    in_ready_o = !cmd_vld_q || (advance && done);
    cmd_vld_d  = (in_valid_i && in_ready_o) ? 1'b1 : (advance && done) ? 1'b0 : cmd_vld_q;
    frame_d    = frame_q;
    if (advance && is_chaser) begin
      frame_d = done ? '0 : frame_q + 1'b1;
    end
  end

  assign res_valid_o = cmd_vld_q && emit;
  assign res_o       = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fb_q      <= 1'b1;
      cmd_vld_q <= 1'b0;
      frame_q   <= '0;
      image_q   <= '0;
      da_q      <= 1'b0;
      db_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        fb_q <= cfg_wdata_i;
      end
      cmd_vld_q <= cmd_vld_d;
      frame_q   <= frame_d;
      if (advance) begin
        image_q <= image_d;
        da_q    <= da_d;
        db_q    <= db_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q <= in_cmd_i;
    end
  end

`ifndef NO_ASSERTIONS
  a_chaser_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_vld_q && cmd_q.req_type == REQ_CHASER && frame_q != CHASER_LAST) |-> !in_ready_o)
    else $error("input accepted in the middle of the chaser");

  a_frame_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_q <= CHASER_LAST)
    else $error("chaser frame counter out of range");

  a_frame_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (frame_q != '0) |-> (cmd_vld_q && cmd_q.req_type == REQ_CHASER))
    else $error("frame counter running without a chaser command");

  a_chaser_ends_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && is_chaser && done) |=> (image_q == '0 && !da_q && !db_q))
    else $error("leds not off after the chaser");
`endif

endmodule

// ===== src/lis_out_reg.sv =====
// lis_out_reg: result register between the engine and the result channel
// depends on lis_pkg
module lis_out_reg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  lis_pkg::res_t data_i,
  output logic          valid_o,
  input  logic          ready_i,
  output lis_pkg::res_t data_o
);
  import lis_pkg::*;

  logic vld_q;
  res_t data_q;

  // refill in the same cycle the held transaction leaves
  assign ready_o = !vld_q || ready_i;
  assign valid_o = vld_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ready_o) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_i;
    end
  end

endmodule

// ===== src/led_indicator_sequencer.sv =====
// a command is held in the engine's command register, and its result in the result register
// throughput: one command per cycle while results are taken; the chaser holds the
//   command register for its 43 frames, one frame per cycle, set by its frame counter
// commands that produce no result retire without waiting on the result register
// reset: asynchronous, active low; leds and image off, feedback enabled
// depends on lis_pkg, lis_if, lis_engine, lis_out_reg
module led_indicator_sequencer (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic cfg_wdata_i,
  lis_cmd_if.sink   req_i,
  lis_res_if.source res_o
);
  import lis_pkg::*;

  cmd_t cmd;
  res_t eng_res, out_res;
  logic eng_valid, eng_ready;

  assign cmd = '{req_i.req_type, req_i.led_number, req_i.led_on, req_i.raw_byte};

  lis_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .in_cmd_i    (cmd),
    .res_valid_o (eng_valid),
    .res_ready_i (eng_ready),
    .res_o       (eng_res)
  );

  lis_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (eng_valid),
    .ready_o (eng_ready),
    .data_i  (eng_res),
    .valid_o (res_o.valid),
    .ready_i (res_o.ready),
    .data_o  (out_res)
  );

  assign res_o.shifted_byte = out_res.shifted_byte;
  assign res_o.shift_pulsed = out_res.shift_pulsed;
  assign res_o.latch_pulsed = out_res.latch_pulsed;
  assign res_o.direct_led_a = out_res.direct_led_a;
  assign res_o.direct_led_b = out_res.direct_led_b;
  assign res_o.hold_ms      = out_res.hold_ms;
  assign res_o.last         = out_res.last;

endmodule

// ===== dv/lis_frame_checker.sv =====
// lis_frame_checker: watches the command and result channels of the led indicator sequencer,
// keeps its own copy of the shift image and direct leds, and checks every result frame
// depends on lis_pkg and lis_if
module lis_frame_checker (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic cfg_wdata_i,
  lis_cmd_if   req_i,
  lis_res_if   res_i,
  output int   fail_cnt_o,
  output int   pending_o
);
  import lis_pkg::*;

  localparam int SLOT_NONE     = -1;
  localparam int SLOT_DIRECT_A = 8;
  localparam int SLOT_DIRECT_B = 9;
  localparam int NUM_IND       = 10;
  localparam int MAX_REPORTS   = 10;

  localparam logic [6:0] HOLD_WIPE_ON  = 7'd40;
  localparam logic [6:0] HOLD_WIPE_OFF = 7'd20;
  localparam logic [6:0] HOLD_PHASE    = 7'd80;
  localparam logic [6:0] HOLD_NONE     = 7'd0;
  localparam logic [7:0] MAX_BIT       = 8'd7;

  logic [7:0] image;
  logic       led_a;
  logic       led_b;
  logic       feedback_on;
  res_t       frames_due[$];
  int         fails = 0;

  // indicator number to shift bit, or to one of the direct leds
  function automatic int slot_of(input int n);
    case (n)
      1:       return 0;
      2:       return 2;
      3:       return 4;
      4:       return 6;
      5:       return 1;
      6:       return SLOT_DIRECT_A;
      7:       return 3;
      8:       return SLOT_DIRECT_B;
      9:       return 7;
      10:      return 5;
      default: return SLOT_NONE;
    endcase
  endfunction

  function automatic ind_kind_e light(input int n, input logic on);
    int s;
    s = slot_of(n);
    if (s == SLOT_NONE) return IND_NONE;
    if (s == SLOT_DIRECT_A) begin
      led_a = on;
      return IND_DIRECT_A;
    end
    if (s == SLOT_DIRECT_B) begin
      led_b = on;
      return IND_DIRECT_B;
    end
    image[s] = on;
    return IND_SHIFT;
  endfunction

  function automatic void clear_leds();
    image = '0;
    led_a = 1'b0;
    led_b = 1'b0;
  endfunction

  // direct led states are taken after the update that caused the frame
  function automatic void push_frame(input logic [7:0] b, input logic sh, input logic la,
                                     input logic [6:0] hold, input logic fin);
    res_t r;
    r.shifted_byte = b;
    r.shift_pulsed = sh;
    r.latch_pulsed = la;
    r.direct_led_a = led_a;
    r.direct_led_b = led_b;
    r.hold_ms      = hold;
    r.last         = fin;
    frames_due.push_back(r);
  endfunction

  function automatic void run_chaser();
    logic odd;
    clear_leds();
    for (int i = 1; i <= NUM_IND; i++) begin
      void'(light(i, 1'b1));
      push_frame(image, 1'b1, 1'b1, HOLD_WIPE_ON, 1'b0);
    end
    for (int i = 1; i <= NUM_IND; i++) begin
      void'(light(i, 1'b0));
      push_frame(image, 1'b1, 1'b1, HOLD_WIPE_OFF, 1'b0);
    end
    // single dot forward, then backward; the dot goes off after its frame
    for (int i = 1; i <= NUM_IND; i++) begin
      void'(light(i, 1'b1));
      push_frame(image, 1'b1, 1'b1, HOLD_WIPE_ON, 1'b0);
      void'(light(i, 1'b0));
    end
    for (int i = NUM_IND; i >= 1; i--) begin
      void'(light(i, 1'b1));
      push_frame(image, 1'b1, 1'b1, HOLD_WIPE_ON, 1'b0);
      void'(light(i, 1'b0));
    end
    for (int ph = 0; ph < 2; ph++) begin
      for (int i = 1; i <= NUM_IND; i++) begin
        odd = (i % 2) == 1;
        void'(light(i, (ph == 0) ? odd : !odd));
      end
      push_frame(image, 1'b1, 1'b1, HOLD_PHASE, 1'b0);
    end
    clear_leds();
    push_frame(image, 1'b1, 1'b1, HOLD_NONE, 1'b1);
  endfunction

  function automatic void predict_frames(input cmd_t c);
    ind_kind_e k;
    case (c.req_type)
      REQ_SET_IND: begin
        if (!feedback_on) begin
          clear_leds();
          push_frame(image, 1'b1, 1'b1, HOLD_NONE, 1'b1);
        end else begin
          k = light(int'(c.led_number), c.led_on);
          if (k == IND_SHIFT) begin
            push_frame(image, 1'b1, 1'b1, HOLD_NONE, 1'b1);
          end else if (k != IND_NONE) begin
            push_frame(8'h00, 1'b0, 1'b0, HOLD_NONE, 1'b1);
          end
        end
      end
      REQ_CLEAR: begin
        clear_leds();
        push_frame(image, 1'b1, 1'b1, HOLD_NONE, 1'b1);
      end
      REQ_CHASER: begin
        run_chaser();
      end
      REQ_SET_BIT: begin
        if (c.led_number <= MAX_BIT) begin
          image[c.led_number[2:0]] = c.led_on;
          push_frame(image, 1'b1, 1'b1, HOLD_NONE, 1'b1);
        end
      end
      REQ_RESEND: begin
        push_frame(image, 1'b1, 1'b1, HOLD_NONE, 1'b1);
      end
      REQ_RAW: begin
        push_frame(c.raw_byte, 1'b1, 1'b0, HOLD_NONE, 1'b1);
      end
      default: ;
    endcase
  endfunction

  function automatic string show(input res_t r);
    return $sformatf("byte=%02h sh=%b la=%b a=%b b=%b hold=%0d last=%b", r.shifted_byte,
                     r.shift_pulsed, r.latch_pulsed, r.direct_led_a, r.direct_led_b,
                     r.hold_ms, r.last);
  endfunction

  // result is checked before the command of the same edge, which cannot have caused it
  always @(posedge clk_i or negedge rst_ni) begin
    res_t seen;
    res_t want;
    cmd_t c;
    if (!rst_ni) begin
      frames_due.delete();
      clear_leds();
      feedback_on = 1'b1;
    end else begin
      if (res_i.valid && res_i.ready) begin
        seen.shifted_byte = res_i.shifted_byte;
        seen.shift_pulsed = res_i.shift_pulsed;
        seen.latch_pulsed = res_i.latch_pulsed;
        seen.direct_led_a = res_i.direct_led_a;
        seen.direct_led_b = res_i.direct_led_b;
        seen.hold_ms      = res_i.hold_ms;
        seen.last         = res_i.last;
        if (frames_due.size() == 0) begin
          fails++;
          if (fails <= MAX_REPORTS) $display("unexpected result: %s", show(seen));
        end else begin
          want = frames_due.pop_front();
          if (seen !== want) begin
            fails++;
            if (fails <= MAX_REPORTS) begin
              $display("result mismatch: expected %s", show(want));
              $display("                 actual   %s", show(seen));
            end
          end
        end
      end
      if (req_i.valid && req_i.ready) begin
        c.req_type   = req_i.req_type;
        c.led_number = req_i.led_number;
        c.led_on     = req_i.led_on;
        c.raw_byte   = req_i.raw_byte;
        predict_frames(c);
      end
      if (cfg_we_i) feedback_on = cfg_wdata_i;
    end
    fail_cnt_o <= fails;
    pending_o  <= frames_due.size();
  end

endmodule

// ===== dv/tb.sv =====
// tb: drives commands, feedback settings and result backpressure into the led indicator
// sequencer and gives the verdict from the frame checker
// depends on lis_pkg, lis_if, lis_frame_checker and the led_indicator_sequencer rtl
module tb;
  import lis_pkg::*;

  localparam int GAP_MAX        = 18;
  localparam int WATCHDOG_LIMIT = 300;
  localparam int RANDOM_ITEMS   = 250;
  localparam int PHASES         = 5;
  localparam int SETTLE_CYCLES  = 4;

  localparam logic [2:0] REQ_SPARE_LO = 3'd6;
  localparam logic [2:0] REQ_SPARE_HI = 3'd7;
  localparam logic [7:0] MIN_IND      = 8'd1;
  localparam logic [7:0] MAX_IND      = 8'd10;
  localparam logic [7:0] MAX_BIT      = 8'd7;

  logic clk_i;
  logic rst_ni;
  logic cfg_we;
  logic cfg_wdata;
  logic feedback_now;
  bit   tx_quiet;
  bit   rx_quiet;
  int   fail_cnt;
  int   pending;
  int   stuck_cycles = 0;

  lis_cmd_if req_ch ();
  lis_res_if res_ch ();

  led_indicator_sequencer uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (req_ch),
    .res_o       (res_ch)
  );

  lis_frame_checker frame_chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (req_ch),
    .res_i       (res_ch),
    .fail_cnt_o  (fail_cnt),
    .pending_o   (pending)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // counts edges at which neither channel moves a transaction
  always @(posedge clk_i) begin
    if (rst_ni !== 1'b1 || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic cmd_t make_cmd(input logic [2:0] t, input logic [7:0] n, input logic on,
                                    input logic [7:0] raw);
    cmd_t c;
    c.req_type   = t;
    c.led_number = n;
    c.led_on     = on;
    c.raw_byte   = raw;
    return c;
  endfunction

  // mostly well-formed commands, some out-of-range numbers and spare types
  function automatic cmd_t random_command();
    cmd_t c;
    int   pick;
    c.led_number = 8'($urandom_range(0, 255));
    c.led_on     = 1'($urandom_range(0, 1));
    c.raw_byte   = 8'($urandom_range(0, 255));
    pick         = $urandom_range(0, 99);
    if (pick < 40) begin
      c.req_type = REQ_SET_IND;
      if ($urandom_range(0, 9) < 8) c.led_number = 8'($urandom_range(MIN_IND, MAX_IND));
    end else if (pick < 55) begin
      c.req_type = REQ_SET_BIT;
      if ($urandom_range(0, 9) < 8) c.led_number = 8'($urandom_range(0, MAX_BIT));
    end else if (pick < 65) begin
      c.req_type = REQ_CLEAR;
    end else if (pick < 75) begin
      c.req_type = REQ_RESEND;
    end else if (pick < 90) begin
      c.req_type = REQ_RAW;
    end else if (pick < 94) begin
      c.req_type = REQ_CHASER;
    end else begin
      c.req_type = 3'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI));
    end
    return c;
  endfunction

  task automatic send(input cmd_t c);
    int gap;
    if ($urandom_range(0, 19) == 0) tx_quiet = !tx_quiet;
    gap = tx_quiet ? 0 : $urandom_range(0, GAP_MAX);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_ch.valid      <= 1'b1;
    req_ch.req_type   <= c.req_type;
    req_ch.led_number <= c.led_number;
    req_ch.led_on     <= c.led_on;
    req_ch.raw_byte   <= c.raw_byte;
    do @(posedge clk_i); while (req_ch.ready !== 1'b1);
  endtask

  // hold off until every predicted frame is back and the block has gone quiet
  task automatic settle();
    req_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_feedback(input logic v);
    settle();
    cfg_we       <= 1'b1;
    cfg_wdata    <= v;
    feedback_now = v;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int   stall;
    res_ch.ready <= 1'b0;
    do @(posedge clk_i); while (rst_ni !== 1'b1);
    forever begin
      if ($urandom_range(0, 19) == 0) rx_quiet = !rx_quiet;
      stall = rx_quiet ? 0 : $urandom_range(0, GAP_MAX);
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk_i); while (res_ch.valid !== 1'b1);
    end
  end

  initial begin
    int   counted;
    cmd_t c;
    rst_ni            <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_wdata         <= 1'b0;
    req_ch.valid      <= 1'b0;
    req_ch.req_type   <= REQ_SET_IND;
    req_ch.led_number <= 8'h00;
    req_ch.led_on     <= 1'b0;
    req_ch.raw_byte   <= 8'h00;
    feedback_now      = 1'b1;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // feedback on: shift and direct indicators, bad numbers, every request type
    send(make_cmd(REQ_SET_IND, 8'd1, 1'b1, 8'h00));
    send(make_cmd(REQ_SET_IND, 8'd10, 1'b1, 8'hFF));
    send(make_cmd(REQ_SET_IND, 8'd6, 1'b1, 8'h00));
    send(make_cmd(REQ_SET_IND, 8'd8, 1'b1, 8'h00));
    send(make_cmd(REQ_SET_IND, 8'd0, 1'b1, 8'h00));
    send(make_cmd(REQ_SET_IND, 8'd11, 1'b1, 8'h00));
    send(make_cmd(REQ_SET_IND, 8'd255, 1'b0, 8'h00));
    send(make_cmd(REQ_SET_IND, 8'd1, 1'b0, 8'h00));
    send(make_cmd(REQ_SET_BIT, 8'd0, 1'b1, 8'h00));
    send(make_cmd(REQ_SET_BIT, 8'd7, 1'b1, 8'h00));
    send(make_cmd(REQ_SET_BIT, 8'd8, 1'b1, 8'h00));
    send(make_cmd(REQ_SET_BIT, 8'd255, 1'b1, 8'hFF));
    send(make_cmd(REQ_RESEND, 8'd0, 1'b0, 8'h00));
    send(make_cmd(REQ_RAW, 8'd0, 1'b0, 8'hFF));
    send(make_cmd(REQ_RAW, 8'd255, 1'b1, 8'h00));
    send(make_cmd(REQ_SPARE_LO, 8'd255, 1'b1, 8'hFF));
    send(make_cmd(REQ_SPARE_HI, 8'd3, 1'b0, 8'h5A));
    send(make_cmd(REQ_CHASER, 8'd0, 1'b0, 8'h00));
    send(make_cmd(REQ_RESEND, 8'd0, 1'b0, 8'h00));
    send(make_cmd(REQ_SET_IND, 8'd6, 1'b1, 8'h00));
    send(make_cmd(REQ_CLEAR, 8'd0, 1'b0, 8'h00));

    // feedback off: any set-indicator request wipes everything
    set_feedback(1'b0);
    send(make_cmd(REQ_SET_IND, 8'd3, 1'b1, 8'h00));
    send(make_cmd(REQ_SET_IND, 8'd200, 1'b1, 8'h00));
    send(make_cmd(REQ_SET_BIT, 8'd5, 1'b1, 8'h00));
    send(make_cmd(REQ_CHASER, 8'd0, 1'b1, 8'h00));
    set_feedback(1'b1);

    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) set_feedback(p != 2 && $urandom_range(0, 3) != 0);
      counted = 0;
      while (counted < RANDOM_ITEMS / PHASES) begin
        c = random_command();
        // ignored requests do not count toward the phase length
        if (c.req_type <= REQ_RAW &&
            !(c.req_type == REQ_SET_BIT && c.led_number > MAX_BIT) &&
            !(c.req_type == REQ_SET_IND && feedback_now &&
              (c.led_number < MIN_IND || c.led_number > MAX_IND))) begin
          counted++;
        end
        send(c);
      end
    end

    settle();
    if (fail_cnt == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== led_indicator_sequencer.f =====
src/lis_pkg.sv
src/lis_if.sv
src/lis_engine.sv
src/lis_out_reg.sv
src/led_indicator_sequencer.sv
dv/lis_frame_checker.sv
dv/tb.sv
